@@ src/ndps_pkg.sv @@
package ndps_pkg;

	localparam int unsigned POS_W = 6;
	localparam int unsigned VAL_W = 16;
	localparam int unsigned SUM_W = 32;
	localparam int unsigned ACT_W = 16;
	localparam int unsigned FRAC_W = 24;
	localparam int unsigned LUT_IDX_W = 5;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [ACT_W-1:0] act_t;

	typedef enum logic {
		MODE_LOAD = 1'b0,
		MODE_ELEM = 1'b1
	} mode_t;

	// sum clamp window for the activation, [-8, 8) in Q8.24
	localparam sum_t CLAMP_LO = 32'shF800_0000;
	localparam sum_t CLAMP_HI = 32'sh07FF_FFFF;

	localparam sum_t SUM_MAX = 32'sh7FFF_FFFF;
	localparam sum_t SUM_MIN = 32'sh8000_0000;

	// activation bounds, the first and last table points
	localparam act_t ACT_MIN = 16'd23;
	localparam act_t ACT_MID = 16'd32768;
	localparam act_t ACT_MAX = 16'd65513;

	// element beat held between the weight read and the multiplier
	typedef struct packed {
		logic   last;
		logic   in_range;
		value_t value;
	} elem_t;

	// finished dot product handed to the activation path
	typedef struct packed {
		sum_t sum;
		logic sat;
	} sum_beat_t;

	// sigmoid at the integer points -8..8, unsigned Q0.16
	function automatic act_t sig_lut(input logic [LUT_IDX_W-1:0] k);
		act_t r;
		case (k)
			5'd0:    r = 16'd23;
			5'd1:    r = 16'd61;
			5'd2:    r = 16'd165;
			5'd3:    r = 16'd445;
			5'd4:    r = 16'd1193;
			5'd5:    r = 16'd3135;
			5'd6:    r = 16'd7854;
			5'd7:    r = 16'd17665;
			5'd8:    r = 16'd32768;
			5'd9:    r = 16'd47871;
			5'd10:   r = 16'd57682;
			5'd11:   r = 16'd62401;
			5'd12:   r = 16'd64343;
			5'd13:   r = 16'd65091;
			5'd14:   r = 16'd65371;
			5'd15:   r = 16'd65475;
			5'd16:   r = 16'd65513;
			default: r = 16'd65513;
		endcase
		return r;
	endfunction

endpackage

@@ src/ndps_item_if.sv @@
interface ndps_item_if;
	import ndps_pkg::*;

	logic                valid;
	logic                ready;
	logic                mode;
	logic [POS_W-1:0]    position;
	value_t              value;
	logic                last;

	modport source (output valid, output mode, output position, output value, output last,
		input ready);
	modport sink (input valid, input mode, input position, input value, input last,
		output ready);
endinterface

@@ src/ndps_result_if.sv @@
interface ndps_result_if;
	import ndps_pkg::*;

	logic   valid;
	logic   ready;
	act_t   activation;
	sum_t   weighted_sum;
	logic   saturated;

	modport source (output valid, output activation, output weighted_sum, output saturated,
		input ready);
	modport sink (input valid, input activation, input weighted_sum, input saturated,
		output ready);
endinterface

@@ src/neuron_dot_product_sigmoid_unit.sv @@
// Single neuron: a weight store, a saturating multiply-accumulate and a sigmoid
// activation, streaming one beat per clock. An item beat with mode 0 writes its
// Q4.12 value into the weight store at position (ignored at or beyond NUM_WEIGHTS);
// mode 1 multiplies the value by the stored weight at the same position and adds
// the Q8.24 product into a 32-bit accumulator that clamps at its limits. A mode 1
// beat with last set emits one result beat: the saturated sum, a flag that any add
// of the vector clamped, and the sigmoid of the sum as unsigned Q0.16 (17-point
// table over [-8, 8) with linear interpolation); the accumulator then clears.
// Weights must be written before they are used; the store is not cleared at reset.
// Throughput is one item per cycle while the result path has room, set by the
// accumulate loop. After its last element is taken, a result beat passes these
// registers in order: weight read, multiply, accumulate, table lookup with
// interpolation multiply, then the output register. The item side keeps taking beats
// while a result waits, until the result path itself fills up.
module neuron_dot_product_sigmoid_unit #(
	parameter int unsigned NUM_WEIGHTS = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	ndps_item_if.sink      item,
	ndps_result_if.source  result
);
	import ndps_pkg::*;

	// address width of the weight store, at least one bit
	localparam int unsigned AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

	// item acceptance and weight store access
	logic          accept;
	logic          in_range;
	logic [AW-1:0] addr;
	logic          wr_en;
	logic          rd_en;

	// stage 1: element waiting for its weight
	logic          valid_s1;
	logic          last_s1;
	logic          in_range_s1;
	value_t        value_s1;
	value_t        weight;
	elem_t         elem;
	logic          mac_ready;

	// accumulator to activation hand-off
	logic          sum_valid;
	logic          sum_ready;
	sum_beat_t     sum_beat;

	assign item.ready = !valid_s1 || mac_ready;
	assign accept     = item.valid && item.ready;

	// positions past the store are dropped for loads and contribute zero for elements
	assign in_range = 32'(item.position) < 32'(NUM_WEIGHTS);
	assign addr     = AW'(item.position);
	assign wr_en    = accept && (item.mode == MODE_LOAD) && in_range;
	assign rd_en    = accept && (item.mode == MODE_ELEM);

	ndps_weight_mem #(
		.DEPTH (NUM_WEIGHTS),
		.AW    (AW)
	) u_weight_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (item.value),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (weight)
	);

	// stage 1 lines up with the registered weight read; loads never enter it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			last_s1     <= item.last;
			in_range_s1 <= in_range;
			value_s1    <= item.value;
		end
	end

	assign elem.last     = last_s1;
	assign elem.in_range = in_range_s1;
	assign elem.value    = value_s1;

	// multiply and saturating accumulate
	ndps_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.elem_valid (valid_s1),
		.elem_ready (mac_ready),
		.elem       (elem),
		.weight     (weight),
		.sum_valid  (sum_valid),
		.sum_ready  (sum_ready),
		.sum_beat   (sum_beat)
	);

	// clamp, table lookup, interpolation and the output register
	ndps_sigmoid u_sigmoid (
		.clk       (clk),
		.arst_n    (arst_n),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum_beat  (sum_beat),
		.result    (result)
	);

`ifndef SYNTHESIS
	// a weight write never coincides with an element read
	assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("weight write and read in the same cycle");

	// an empty stage 1 never blocks the item side
	assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> item.ready)
		else $error("item side stalled with stage 1 empty");
`endif
endmodule

@@ src/ndps_weight_mem.sv @@
module ndps_weight_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW = 6
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  ndps_pkg::value_t       wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output ndps_pkg::value_t       rd_data
);
	import ndps_pkg::*;

	value_t mem [DEPTH];
	value_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

@@ src/ndps_mac.sv @@
module ndps_mac (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  elem_valid,
	output logic                  elem_ready,
	input  ndps_pkg::elem_t       elem,
	input  ndps_pkg::value_t      weight,
	output logic                  sum_valid,
	input  logic                  sum_ready,
	output ndps_pkg::sum_beat_t   sum_beat
);
	import ndps_pkg::*;

	logic      valid_s2;
	logic      last_s2;
	sum_t      prod_s2;

	sum_t      acc_q;
	logic      ovf_q;

	logic      valid_s3;
	sum_beat_t beat_s3;

	logic                acc_ready;
	logic                adv_s2;
	logic signed [SUM_W:0] wide_sum;
	logic                ovf_add;
	sum_t                acc_next;
	logic                ovf_next;

	assign acc_ready  = !valid_s3 || sum_ready;
	assign adv_s2     = valid_s2 && acc_ready;
	assign elem_ready = !valid_s2 || acc_ready;

	// multiplier stage, out-of-range elements contribute nothing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (elem_ready) begin
			valid_s2 <= elem_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (elem_ready && elem_valid) begin
			last_s2 <= elem.last;
			prod_s2 <= elem.in_range ? SUM_W'(elem.value * weight) : '0;
		end
	end

	// saturating accumulate
	always_comb begin
		wide_sum = {acc_q[SUM_W-1], acc_q} + {prod_s2[SUM_W-1], prod_s2};
		ovf_add  = wide_sum[SUM_W] != wide_sum[SUM_W-1];
		if (!ovf_add) begin
			acc_next = wide_sum[SUM_W-1:0];
		end else if (wide_sum[SUM_W]) begin
			acc_next = SUM_MIN;
		end else begin
			acc_next = SUM_MAX;
		end
		ovf_next = ovf_q || ovf_add;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (adv_s2) begin
			if (last_s2) begin
				acc_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				ovf_q <= ovf_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (acc_ready) begin
			valid_s3 <= adv_s2 && last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && last_s2) begin
			beat_s3.sum <= acc_next;
			beat_s3.sat <= ovf_next;
		end
	end

	assign sum_valid = valid_s3;
	assign sum_beat  = beat_s3;

`ifndef SYNTHESIS
	// a closing element leaves a clean accumulator behind
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && last_s2 |=> acc_q == '0 && !ovf_q)
		else $error("accumulator not cleared after last element");

	// a closing element that never clamped gives a result beat with no saturation flag
	assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && last_s2 && !ovf_next |=> valid_s3 && !beat_s3.sat)
		else $error("result beat lost or flag mismatch");
`endif
endmodule

@@ src/ndps_sigmoid.sv @@
module ndps_sigmoid (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sum_valid,
	output logic                  sum_ready,
	input  ndps_pkg::sum_beat_t   sum_beat,
	ndps_result_if.source         result
);
	import ndps_pkg::*;

	logic              valid_s4;
	act_t              base_s4;
	act_t              interp_s4;
	sum_beat_t         beat_s4;

	logic              valid_q;
	act_t              act_q;
	sum_beat_t         beat_q;

	sum_t                      clamped;
	logic [SUM_W-5:0]          offset;
	logic [LUT_IDX_W-1:0]      seg;
	logic [FRAC_W-1:0]         frac;
	act_t                      base;
	act_t                      diff;
	logic [ACT_W+FRAC_W-1:0]   prod;
	logic                      out_free;
	logic                      adv_s4;

	assign out_free  = !valid_q || result.ready;
	assign adv_s4    = valid_s4 && out_free;
	assign sum_ready = !valid_s4 || out_free;

	// clamp to [-8, 8), shift up by 8, split into segment and fraction, look up and interpolate
	always_comb begin
		if (sum_beat.sum < CLAMP_LO) begin
			clamped = CLAMP_LO;
		end else if (sum_beat.sum > CLAMP_HI) begin
			clamped = CLAMP_HI;
		end else begin
			clamped = sum_beat.sum;
		end
		offset = {~clamped[SUM_W-5], clamped[SUM_W-6:0]};
		seg    = {1'b0, offset[SUM_W-5:FRAC_W]};
		frac   = offset[FRAC_W-1:0];
		base   = sig_lut(seg);
		diff   = sig_lut(seg + LUT_IDX_W'(1)) - base;
		prod   = (ACT_W+FRAC_W)'(diff) * (ACT_W+FRAC_W)'(frac);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (sum_ready) begin
			valid_s4 <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_ready && sum_valid) begin
			base_s4   <= base;
			interp_s4 <= prod[ACT_W+FRAC_W-1:FRAC_W];
			beat_s4   <= sum_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			act_q  <= base_s4 + interp_s4;
			beat_q <= beat_s4;
		end
	end

	assign result.valid        = valid_q;
	assign result.activation   = act_q;
	assign result.weighted_sum = beat_q.sum;
	assign result.saturated    = beat_q.sat;

`ifndef SYNTHESIS
	// interpolation never leaves the table's span
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> act_q >= ACT_MIN && act_q <= ACT_MAX)
		else $error("activation outside table range");

	// sign of the sum decides which half of the curve we are on
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !beat_q.sum[SUM_W-1] |-> act_q >= ACT_MID)
		else $error("non-negative sum gave activation below one half");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && beat_q.sum[SUM_W-1] |-> act_q <= ACT_MID)
		else $error("negative sum gave activation above one half");
`endif
endmodule

@@ tb/neuron_result_checker.sv @@
module neuron_result_checker
	import ndps_pkg::*;
#(
	parameter int unsigned NUM_WEIGHTS = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	ndps_item_if   item,
	ndps_result_if result,
	output int     errors,
	output int     outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		act_t act;
		sum_t sum;
		logic sat;
	} neuron_out_t;

	// sigmoid at the integer points -8..8, unsigned Q0.16
	localparam act_t SIG_PTS [0:16] = '{
		16'd23, 16'd61, 16'd165, 16'd445, 16'd1193, 16'd3135, 16'd7854, 16'd17665,
		16'd32768,
		16'd47871, 16'd57682, 16'd62401, 16'd64343, 16'd65091, 16'd65371, 16'd65475,
		16'd65513
	};

	value_t      weights [NUM_WEIGHTS];
	sum_t        acc;
	logic        sat_seen;
	neuron_out_t neuron_out_q [$];

	initial errors = 0;

	function automatic act_t interp_sigmoid(sum_t x);
		sum_t              c;
		logic [31:0]       u;
		logic [3:0]        seg;
		logic [23:0]       frac;
		longint unsigned   span;
		c = x;
		if (c < CLAMP_LO) c = CLAMP_LO;
		if (c > CLAMP_HI) c = CLAMP_HI;
		u = c - CLAMP_LO;
		seg = u[27:24];
		frac = u[23:0];
		span = SIG_PTS[seg + 1] - SIG_PTS[seg];
		return SIG_PTS[seg] + act_t'((span * frac) >> 24);
	endfunction

	function automatic void neuron_step(mode_t m, logic [POS_W-1:0] pos, value_t v, logic lst);
		longint      s;
		neuron_out_t o;
		if (m == MODE_LOAD) begin
			if (pos < NUM_WEIGHTS) weights[pos] = v;
			return;
		end
		if (pos < NUM_WEIGHTS) begin
			s = longint'(acc) + longint'(v) * longint'(weights[pos]);
			if (s > longint'(SUM_MAX)) begin
				s = longint'(SUM_MAX);
				sat_seen = 1'b1;
			end else if (s < longint'(SUM_MIN)) begin
				s = longint'(SUM_MIN);
				sat_seen = 1'b1;
			end
			acc = sum_t'(s);
		end
		if (!lst) return;
		o.act = interp_sigmoid(acc);
		o.sum = acc;
		o.sat = sat_seen;
		neuron_out_q = {neuron_out_q, o};
		acc = '0;
		sat_seen = 1'b0;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%t neuron_result_checker: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_output(act_t a, sum_t s, logic st);
		neuron_out_t e;
		if (neuron_out_q.size() == 0) begin
			report_mismatch($sformatf("result beat with nothing pending, sum %0d", s));
			return;
		end
		e = neuron_out_q.pop_front();
		if (a !== e.act)
			report_mismatch($sformatf("activation %0d, want %0d (sum %0d)", a, e.act, e.sum));
		if (s !== e.sum)
			report_mismatch($sformatf("weighted_sum %0d, want %0d", s, e.sum));
		if (st !== e.sat)
			report_mismatch($sformatf("saturated %b, want %b (sum %0d)", st, e.sat, e.sum));
	endtask

	// result first: a beat taken on this edge cannot produce a result on the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc = '0;
			sat_seen = 1'b0;
			neuron_out_q.delete();
			outstanding <= 0;
		end else begin
			if (result.valid && result.ready)
				check_output(result.activation, result.weighted_sum, result.saturated);
			if (item.valid && item.ready)
				neuron_step(mode_t'(item.mode), item.position, item.value, item.last);
			outstanding <= neuron_out_q.size();
		end
	end

endmodule

@@ tb/tb_neuron_dot_product_sigmoid_unit.sv @@
module tb_neuron_dot_product_sigmoid_unit;
	import ndps_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_WEIGHTS  = 64;
	localparam int          ITEM_TARGET  = 1150;
	// cycles with no beat on either side before the run is called hung
	localparam int          STALL_LIMIT  = 2000;
	// the result path runs through multiply, accumulate, lookup and output registers; give it some slack
	localparam int          DRAIN_CYCLES = 12;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	ndps_item_if   item_ch ();
	ndps_result_if result_ch ();

	int   errors;
	int   outstanding;
	int   idle_pct  = 0;
	int   stall_pct = 0;
	int   sent      = 0;
	int   quiet_cycles = 0;

	// weights written so far; elements only ever pair with these
	logic wt_loaded [NUM_WEIGHTS];
	int   loaded_idx [$];

	always #6 clk = ~clk;

	neuron_dot_product_sigmoid_unit #(
		.NUM_WEIGHTS(NUM_WEIGHTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	neuron_result_checker #(
		.NUM_WEIGHTS(NUM_WEIGHTS)
	) out_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.errors      (errors),
		.outstanding (outstanding)
	);

	// result side back-pressure, redrawn every cycle
	initial result_ch.ready = 1'b0;
	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// hang detector: any beat on either channel resets the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_neuron_dot_product_sigmoid_unit: done, errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// mix of extremes, full-range noise and modest values that keep sums in the
	// interpolated part of the sigmoid
	function automatic value_t pick_value();
		case ($urandom_range(9))
			0:       return 16'sh7FFF;
			1:       return 16'sh8000;
			2:       return 16'sh0000;
			3, 4, 5: return value_t'($urandom);
			default: return value_t'(int'($urandom_range(12288)) - 6144);
		endcase
	endfunction

	// one item beat; valid stays high on return so back-to-back beats need no gap
	task automatic drive_beat(mode_t m, int p, value_t v, logic l);
		while ($urandom_range(99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			item_ch.value <= value_t'($urandom);
			@(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.mode     <= m;
		item_ch.position <= POS_W'(p);
		item_ch.value    <= v;
		item_ch.last     <= l;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		if (m == MODE_LOAD && p < NUM_WEIGHTS && !wt_loaded[p]) begin
			wt_loaded[p] = 1'b1;
			loaded_idx = {loaded_idx, p};
		end
		sent++;
	endtask

	// one input vector; weight loads are sprinkled in between its elements,
	// some of them carrying a stray last that the block must ignore
	task automatic send_vector(int len);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 12)
				drive_beat(MODE_LOAD, int'($urandom_range(NUM_WEIGHTS - 1)), pick_value(),
					1'($urandom_range(1)));
			drive_beat(MODE_ELEM, loaded_idx[$urandom_range(loaded_idx.size() - 1)],
				pick_value(), k == len - 1);
		end
	endtask

	initial begin
		int len;
		foreach (wt_loaded[i]) wt_loaded[i] = 1'b0;
		item_ch.valid    <= 1'b0;
		item_ch.mode     <= MODE_LOAD;
		item_ch.position <= '0;
		item_ch.value    <= '0;
		item_ch.last     <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, back to back
		drive_beat(MODE_LOAD, 0, 16'sh7FFF, 1'b0);
		drive_beat(MODE_LOAD, 63, 16'sh8000, 1'b1);   // last on a load gives nothing
		drive_beat(MODE_LOAD, 1, 16'sh1000, 1'b0);    // +1.0
		drive_beat(MODE_LOAD, 2, 16'shF000, 1'b0);    // -1.0
		drive_beat(MODE_LOAD, 3, 16'sh0000, 1'b1);
		// zero sum lands on the table midpoint
		drive_beat(MODE_ELEM, 3, 16'sh7FFF, 1'b1);
		// sum of exactly -8.0, the bottom of the clamp window
		drive_beat(MODE_ELEM, 1, 16'sh8000, 1'b1);
		// just under +8.0, top of the window
		drive_beat(MODE_ELEM, 1, 16'sh7FFF, 1'b1);
		// two-element vector, +1.0 + 0.5
		drive_beat(MODE_ELEM, 2, 16'shF000, 1'b0);
		drive_beat(MODE_ELEM, 1, 16'sh0800, 1'b1);
		// positive overflow, then a zero-weight element closes the vector
		repeat (3) drive_beat(MODE_ELEM, 0, 16'sh7FFF, 1'b0);
		drive_beat(MODE_ELEM, 3, 16'sh0000, 1'b1);
		// negative overflow; the closing element pulls the sum back in range but
		// the flag has to stick until the vector ends
		repeat (3) drive_beat(MODE_ELEM, 0, 16'sh8000, 1'b0);
		drive_beat(MODE_ELEM, 63, 16'sh8000, 1'b1);
		// flag cleared for the next vector
		drive_beat(MODE_ELEM, 2, 16'sh1000, 1'b1);
		// overwrite a weight, sum far above the clamp window
		drive_beat(MODE_LOAD, 1, 16'sh8000, 1'b0);
		drive_beat(MODE_ELEM, 1, 16'sh8000, 1'b1);

		// random vectors under four idling regimes
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 82; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 82; end
				default: begin idle_pct = 31; stall_pct = 31; end
			endcase
			while (sent < (ph + 1) * ITEM_TARGET / 4) begin
				if ($urandom_range(9) == 0)
					len = $urandom_range(40, 9);
				else
					len = $urandom_range(6, 1);
				send_vector(len);
			end
		end
		item_ch.valid <= 1'b0;
		stall_pct = 0;

		// drain: outstanding is registered, so it may trail the checker's queue
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("tb_neuron_dot_product_sigmoid_unit: done, clean");
		end else begin
			$display("tb_neuron_dot_product_sigmoid_unit: done, errors");
		end
		$finish;
	end

endmodule
